/* src/proximity_merge_slot_table_defines.svh */
// assertion macros for the slot table checker
`ifndef PROXIMITY_MERGE_SLOT_TABLE_DEFINES_SVH
`define PROXIMITY_MERGE_SLOT_TABLE_DEFINES_SVH
// assert that an implication holds at every clock edge out of reset
`define PMST_ASSERT_IMPL(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("%m: check failed");
// assert a plain condition at every clock edge, reset included
`define PMST_ASSERT_ALWAYS(label, clk, cond) \
   label: assert property (@(posedge clk) (cond)) else $error("%m: check failed");
`endif

/* src/pmst_pkg.sv */
// package: types, codes and constants of the slot table
`timescale 1ns / 1ps
package pmst_pkg;
   localparam int SLOT_COUNT_DEFAULT = 16;
   localparam logic [15:0] MAX_DEPTH_RESET = 16'd256;
   localparam logic [11:0] MERGE_FACTOR_RESET = 12'd256;

   localparam logic [1:0] OUTCOME_MERGED  = 2'd0;
   localparam logic [1:0] OUTCOME_FILLED  = 2'd1;
   localparam logic [1:0] OUTCOME_DROPPED = 2'd2;

   localparam logic CSR_MAX_DEPTH    = 1'b0;
   localparam logic CSR_MERGE_FACTOR = 1'b1;

   typedef struct packed {
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
      logic signed [15:0] point_z;
      logic signed [15:0] shove_x;
      logic signed [15:0] shove_y;
      logic signed [15:0] shove_z;
      logic signed [15:0] surface_nx;
      logic signed [15:0] surface_ny;
      logic signed [15:0] surface_nz;
      logic [15:0]        hit_radius;
      logic signed [15:0] hit_depth;
   } req_type;

   typedef struct packed {
      logic [1:0]  outcome;
      logic [3:0]  slot_index;
      logic [15:0] slot_depth;
      logic [4:0]  active_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PREP, ST_SCAN, ST_MERGE, ST_FILL, ST_DROP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic prep;
      logic scan_step;
      logic do_merge;
      logic do_fill;
      logic do_drop;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
      logic hit;
      logic any_free;
   } sts_type;
endpackage

/* src/pmst_ctrl.sv */
// controller state machine of the slot table
`timescale 1ns / 1ps
module pmst_ctrl
   import pmst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  sts_type sts,
   output cmd_type cmd
);
   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (start) state_in = ST_PREP;
         ST_PREP:  state_in = ST_SCAN;
         ST_SCAN: begin
            if (sts.hit) state_in = ST_MERGE;
            else if (sts.scan_done) state_in = sts.any_free ? ST_FILL : ST_DROP;
         end
         ST_MERGE: state_in = ST_IDLE;
         ST_FILL:  state_in = ST_IDLE;
         ST_DROP:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // outputs
   always_comb begin
      cmd = '0;
      busy = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE:  cmd.load = start;
         ST_PREP:  cmd.prep = 1'b1;
         ST_SCAN:  cmd.scan_step = !sts.hit && !sts.scan_done;
         ST_MERGE: cmd.do_merge = 1'b1;
         ST_FILL:  cmd.do_fill = 1'b1;
         ST_DROP:  cmd.do_drop = 1'b1;
         default:  cmd = '0;
      endcase
   end
endmodule

/* src/pmst_datapath.sv */
// datapath: slot storage, distance unit, depth update and result register
`timescale 1ns / 1ps
module pmst_datapath
   import pmst_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_data,
   input  cmd_type     cmd,
   output sts_type     sts,
   output logic        rsp_valid,
   output rsp_type     rsp_data
);
   localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CW = $clog2(SLOT_COUNT + 1);

   logic [15:0] max_depth_ff;
   logic [11:0] merge_factor_ff;
   req_type     req_ff;
   logic [15:0] clamped_ff;
   logic [27:0] md_ff;
   logic [55:0] md2_ff;
   logic [SLOT_COUNT-1:0] active_ff;
   logic [CW-1:0] count_ff;
   logic [31:0] stamp_ff;
   logic [IW:0] scan_ff;
   logic [IW-1:0] free_ff;
   logic          free_ok_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   // slot memories, read at the scan pointer
   logic [47:0] point_mem [SLOT_COUNT];
   logic [47:0] shove_mem [SLOT_COUNT];
   logic [47:0] normal_mem [SLOT_COUNT];
   logic [15:0] radius_mem [SLOT_COUNT];
   logic [15:0] depth_mem [SLOT_COUNT];
   logic [31:0] stamp_mem [SLOT_COUNT];
   logic [47:0] rd_point_ff;
   logic [15:0] rd_radius_ff, rd_depth_ff;
   logic        rd_active_ff, rd_valid_ff;
   logic [IW-1:0] rd_idx_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_depth_ff <= MAX_DEPTH_RESET;
         merge_factor_ff <= MERGE_FACTOR_RESET;
      end else if (csr_write) begin
         if (csr_index == CSR_MAX_DEPTH) max_depth_ff <= csr_data;
         else merge_factor_ff <= csr_data[11:0];
      end
   end

   // capture request, clamp depth, first multiply; the square of the product follows on prep
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
         if (req_data.hit_depth[15]) clamped_ff <= '0;
         else if ({1'b0, req_data.hit_depth[14:0]} > max_depth_ff) clamped_ff <= max_depth_ff;
         else clamped_ff <= {1'b0, req_data.hit_depth[14:0]};
         md_ff <= 28'(merge_factor_ff) * 28'(req_data.hit_radius);
      end
      if (cmd.prep) md2_ff <= md_ff * md_ff;
   end

   // scan pointer: issues reads, then a compare stage follows
   logic [IW-1:0] scan_idx;
   assign scan_idx = scan_ff[IW-1:0];
   logic scan_issue;
   assign scan_issue = cmd.prep || cmd.scan_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) scan_ff <= '0;
         else if (scan_issue && scan_ff < (IW+1)'(SLOT_COUNT)) scan_ff <= scan_ff + 1'b1;
         rd_valid_ff <= scan_issue && scan_ff < (IW+1)'(SLOT_COUNT);
      end
   end

   always_ff @(posedge clock) begin
      rd_point_ff <= point_mem[scan_idx];
      rd_radius_ff <= radius_mem[scan_idx];
      rd_depth_ff <= depth_mem[scan_idx];
      rd_active_ff <= active_ff[scan_idx];
      rd_idx_ff <= scan_idx;
   end

   // distance stage: squared differences summed and compared with the reach
   logic signed [16:0] dx, dy, dz;
   assign dx = 17'(req_ff.point_x) - 17'($signed(rd_point_ff[47:32]));
   assign dy = 17'(req_ff.point_y) - 17'($signed(rd_point_ff[31:16]));
   assign dz = 17'(req_ff.point_z) - 17'($signed(rd_point_ff[15:0]));
   logic signed [33:0] sqx, sqy, sqz;
   assign sqx = dx * dx;
   assign sqy = dy * dy;
   assign sqz = dz * dz;
   logic [33:0] sq_sum;
   assign sq_sum = $unsigned(sqx) + $unsigned(sqy) + $unsigned(sqz);
   logic in_reach;
   assign in_reach = ({sq_sum, 16'd0} <= {6'd0, md2_ff}) || (sq_sum == '0);

   logic hit_now;
   assign hit_now = rd_valid_ff && rd_active_ff && in_reach;

   logic hit_seen_ff;

   // keep only the first hit of the scan
   logic [IW-1:0] hit_idx_ff;
   logic [15:0]   hit_depth_ff, hit_radius_ff;
   always_ff @(posedge clock) begin
      if (hit_now && !hit_seen_ff) begin
         hit_idx_ff <= rd_idx_ff;
         hit_depth_ff <= rd_depth_ff;
         hit_radius_ff <= rd_radius_ff;
      end
   end

   // free slot search alongside the scan
   always_ff @(posedge clock) begin
      if (reset || cmd.load) free_ok_ff <= 1'b0;
      else if (rd_valid_ff && !rd_active_ff && !free_ok_ff) begin
         free_ok_ff <= 1'b1;
         free_ff <= rd_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.load) hit_seen_ff <= 1'b0;
      else if (hit_now) hit_seen_ff <= 1'b1;
   end

   assign sts.hit = hit_seen_ff;
   assign sts.scan_done = !rd_valid_ff && (scan_ff == (IW+1)'(SLOT_COUNT));
   assign sts.any_free = free_ok_ff;

   // merged depth
   logic [16:0] dsum;
   logic [15:0] merged_depth;
   assign dsum = {1'b0, hit_depth_ff} + {1'b0, clamped_ff};
   assign merged_depth = (dsum < {1'b0, max_depth_ff}) ? dsum[15:0] : max_depth_ff;

   logic [IW-1:0] wr_idx;
   assign wr_idx = cmd.do_merge ? hit_idx_ff : free_ff;

   // slot writes
   always_ff @(posedge clock) begin
      if (cmd.do_merge || cmd.do_fill) begin
         shove_mem[wr_idx] <= {req_ff.shove_x, req_ff.shove_y, req_ff.shove_z};
         normal_mem[wr_idx] <= {req_ff.surface_nx, req_ff.surface_ny, req_ff.surface_nz};
         stamp_mem[wr_idx] <= stamp_ff;
      end
      if (cmd.do_fill) point_mem[wr_idx] <= {req_ff.point_x, req_ff.point_y, req_ff.point_z};
      if (cmd.do_merge) begin
         depth_mem[wr_idx] <= merged_depth;
         radius_mem[wr_idx] <= (req_ff.hit_radius > hit_radius_ff) ? req_ff.hit_radius
                                                                     : hit_radius_ff;
      end else if (cmd.do_fill) begin
         depth_mem[wr_idx] <= clamped_ff;
         radius_mem[wr_idx] <= req_ff.hit_radius;
      end
   end

   // active bits, count, stamp and result
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         count_ff <= '0;
         stamp_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.do_merge || cmd.do_fill || cmd.do_drop;
         if (cmd.do_merge || cmd.do_fill) stamp_ff <= stamp_ff + 32'd1;
         if (cmd.do_fill) begin
            active_ff[free_ff] <= 1'b1;
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_merge) begin
         rsp_ff.outcome <= OUTCOME_MERGED;
         rsp_ff.slot_index <= 4'(hit_idx_ff);
         rsp_ff.slot_depth <= merged_depth;
         rsp_ff.active_count <= 5'(count_ff);
      end else if (cmd.do_fill) begin
         rsp_ff.outcome <= OUTCOME_FILLED;
         rsp_ff.slot_index <= 4'(free_ff);
         rsp_ff.slot_depth <= clamped_ff;
         rsp_ff.active_count <= 5'(count_ff + 1'b1);
      end else if (cmd.do_drop) begin
         rsp_ff.outcome <= OUTCOME_DROPPED;
         rsp_ff.slot_index <= '0;
         rsp_ff.slot_depth <= '0;
         rsp_ff.active_count <= 5'(count_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule

/* src/proximity_merge_slot_table.sv */
// top level of the proximity merge slot table
//   channel   signals                          transfer when
//   request   start, busy, req_data            start high and busy low
//   result    rsp_valid, rsp_data              rsp_valid high, one cycle
//   config    csr_write, csr_index, csr_data   csr_write high
// with no merge the result strobe comes once the whole table has been scanned:
// the slot scan reads one slot memory entry per cycle. a merge ends the scan
// early, so the later slots are not all read.
// synchronous reset clears active bits, slot count, stamp counter and control registers at once.
// results cannot be stalled; busy drops in the cycle the result is strobed.
`timescale 1ns / 1ps
module proximity_merge_slot_table
   import pmst_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);
   cmd_type cmd;
   sts_type sts;

   pmst_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
   );

   pmst_datapath #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
      .clock(clock), .reset(reset), .req_data(req_data), .csr_write(csr_write),
      .csr_index(csr_index), .csr_data(csr_data), .cmd(cmd), .sts(sts),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );
endmodule

/* src/pmst_checker.sv */
// port-level checker of the slot table, bound to the top level
`timescale 1ns / 1ps
`include "proximity_merge_slot_table_defines.svh"
module pmst_checker
   import pmst_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);
   `PMST_ASSERT_IMPL(a_start_busy, clock, reset, (start && !busy) |=> busy)
   `PMST_ASSERT_IMPL(a_rsp_single, clock, reset, rsp_valid |=> !rsp_valid)
   `PMST_ASSERT_IMPL(a_rsp_code, clock, reset, rsp_valid |-> (rsp_data.outcome != 2'd3))
   `PMST_ASSERT_IMPL(a_drop_zero, clock, reset,
      (rsp_valid && rsp_data.outcome == OUTCOME_DROPPED) |-> (rsp_data.slot_index == '0))
endmodule

bind proximity_merge_slot_table pmst_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data)
);

/* bench/proximity_merge_slot_table_tb.sv */
// self-checking testbench for the proximity merge slot table
`timescale 1ns / 1ps
module proximity_merge_slot_table_tb;
   import pmst_pkg::*;

   localparam int SLOTS = 16;
   localparam int STALL_LIMIT = 2000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_write;
   logic        csr_index;
   logic [15:0] csr_data;

   int error_count;
   int idle_cycles;
   int impacts_sent;
   int merges_seen;
   int fills_seen;
   int drops_seen;

   // mismatch report: one line each, counted
   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   // slot table predictor and queue of predicted results
   class slot_table_scoreboard;
      logic [15:0]        depth_limit;
      logic [11:0]        merge_mult;
      bit                 live [SLOTS];
      logic signed [15:0] px [SLOTS];
      logic signed [15:0] py [SLOTS];
      logic signed [15:0] pz [SLOTS];
      logic [15:0]        radius [SLOTS];
      logic [15:0]        depth [SLOTS];
      logic [31:0]        stamp [SLOTS];
      logic [31:0]        stamp_next;
      rsp_type            pending [$];

      function new();
         depth_limit = MAX_DEPTH_RESET;
         merge_mult = MERGE_FACTOR_RESET;
         foreach (live[i]) live[i] = 0;
         stamp_next = 0;
      endfunction

      function void set_reg(logic idx, logic [15:0] val);
         if (idx == CSR_MAX_DEPTH) depth_limit = val;
         else merge_mult = val[11:0];
      endfunction

      function longint unsigned sq(logic signed [15:0] a, logic signed [15:0] b);
         longint d;
         d = longint'(a) - longint'(b);
         return longint'(d * d);
      endfunction

      // accepted impact: update the table and queue the predicted result
      function void note_impact(req_type r);
         logic [15:0] clamped;
         longint unsigned reach, reach2, d2;
         logic [16:0] sum;
         int hit;
         int n;
         rsp_type e;
         if (r.hit_depth < 0) clamped = 0;
         else if (16'(r.hit_depth) > depth_limit) clamped = depth_limit;
         else clamped = r.hit_depth;
         reach = longint'(merge_mult) * longint'(r.hit_radius);
         reach2 = reach * reach;
         hit = -1;
         e = '{outcome: OUTCOME_DROPPED, slot_index: 0, slot_depth: 0, active_count: 0};
         for (int i = 0; i < SLOTS; i++) begin
            if (hit < 0 && live[i]) begin
               d2 = sq(r.point_x, px[i]) + sq(r.point_y, py[i]) + sq(r.point_z, pz[i]);
               if ((d2 << 16) <= reach2) hit = i;
            end
         end
         if (hit >= 0) begin
            sum = depth[hit] + clamped;
            depth[hit] = (sum < depth_limit) ? sum[15:0] : depth_limit;
            if (r.hit_radius > radius[hit]) radius[hit] = r.hit_radius;
            stamp[hit] = stamp_next;
            stamp_next++;
            e.outcome = OUTCOME_MERGED;
            e.slot_index = 4'(hit);
            e.slot_depth = depth[hit];
         end else begin
            for (int i = 0; i < SLOTS; i++) begin
               if (hit < 0 && !live[i]) begin
                  hit = i;
                  live[i] = 1;
                  px[i] = r.point_x;
                  py[i] = r.point_y;
                  pz[i] = r.point_z;
                  radius[i] = r.hit_radius;
                  depth[i] = clamped;
                  stamp[i] = stamp_next;
                  stamp_next++;
                  e.outcome = OUTCOME_FILLED;
                  e.slot_index = 4'(i);
                  e.slot_depth = clamped;
               end
            end
         end
         n = 0;
         foreach (live[i]) n += live[i];
         e.active_count = 5'(n);
         pending.push_back(e);
      endfunction

      // compare one result strobe with the oldest prediction
      task check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            report("unexpected result", got, 0);
            return;
         end
         want = pending.pop_front();
         if (got.outcome != want.outcome) report("outcome", got.outcome, want.outcome);
         if (got.slot_index != want.slot_index)
            report("slot_index", got.slot_index, want.slot_index);
         if (got.slot_depth != want.slot_depth)
            report("slot_depth", got.slot_depth, want.slot_depth);
         if (got.active_count != want.active_count)
            report("active_count", got.active_count, want.active_count);
      endtask
   endclass

   slot_table_scoreboard board;

   proximity_merge_slot_table dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_write(csr_write),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // result monitor, transfer accounting and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            board.check_result(rsp_data);
            case (rsp_data.outcome)
               OUTCOME_MERGED: merges_seen++;
               OUTCOME_FILLED: fills_seen++;
               default: drops_seen++;
            endcase
         end
         if (start && !busy) board.note_impact(req_data);
         if (rsp_valid || (start && !busy)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("proximity_merge_slot_table verification failed");
            $finish;
         end
      end
   end

   // register write while idle; csr_write drops again before the task returns
   task automatic write_reg(input logic idx, input logic [15:0] val);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 0;
      board.set_reg(idx, val);
      @(posedge clock);
   endtask

   // drop start, wait until all results are in, plus the block latency
   task automatic drain();
      start <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (SLOTS + 8) @(posedge clock);
   endtask

   // drop start and idle for a number of cycles
   task automatic pause(input int cycles);
      if (cycles > 0) begin
         start <= 0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // present one impact and hold it until accepted; start is dropped by the caller
   task automatic send_impact(input req_type r);
      start <= 1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      impacts_sent++;
   endtask

   function automatic req_type random_impact(int spread, bit near);
      req_type r;
      r = req_type'({$urandom, $urandom, $urandom, $urandom, $urandom, 16'($urandom)});
      if (near) begin
         r.point_x = $signed(16'($urandom_range(0, spread))) - 16'(spread / 2);
         r.point_y = $signed(16'($urandom_range(0, spread))) - 16'(spread / 2);
         r.point_z = $signed(16'($urandom_range(0, spread))) - 16'(spread / 2);
         r.hit_radius = 16'($urandom_range(0, 1024));
         if ($urandom_range(0, 3) != 0) r.hit_depth = 16'($urandom_range(0, 1024));
      end
      return r;
   endfunction

   // directed impact with given point, radius and depth
   function automatic req_type make_impact(int x, int y, int z, int rad, int dep);
      req_type r;
      r = req_type'({$urandom, $urandom, $urandom, $urandom, $urandom, 16'($urandom)});
      r.point_x = 16'(x);
      r.point_y = 16'(y);
      r.point_z = 16'(z);
      r.hit_radius = 16'(rad);
      r.hit_depth = 16'(dep);
      return r;
   endfunction

   int gap;
   int burst;

   initial begin
      board = new();
      error_count = 0;
      idle_cycles = 0;
      impacts_sent = 0;
      merges_seen = 0;
      fills_seen = 0;
      drops_seen = 0;
      reset = 1;
      start = 0;
      req_data = '0;
      csr_write = 0;
      csr_index = CSR_MAX_DEPTH;
      csr_data = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, clamp, zero merge distance, lowered limit, full table
      send_impact(make_impact(-32768, -32768, -32768, 65535, 32767));
      send_impact(make_impact(32767, 32767, 32767, 0, -32768));
      send_impact(make_impact(32767, 32767, 32767, 0, 100));
      send_impact(make_impact(0, 0, 0, 256, 200));
      send_impact(make_impact(10, 0, 0, 256, 200));
      drain();
      write_reg(CSR_MERGE_FACTOR, 16'd0);
      send_impact(make_impact(0, 0, 0, 65535, 50));
      send_impact(make_impact(1, 0, 0, 65535, 50));
      drain();
      write_reg(CSR_MAX_DEPTH, 16'd10);
      send_impact(make_impact(0, 0, 0, 1, 5));
      for (int i = 0; i < 14; i++) send_impact(make_impact(i * 700, 5, -9, 3, i));
      drain();
      write_reg(CSR_MAX_DEPTH, 16'hFFFF);
      write_reg(CSR_MERGE_FACTOR, 16'h0FFF);
      send_impact(make_impact(-32768, 32767, 0, 65535, 32767));
      send_impact(make_impact(32767, -32768, 0, 65535, 32767));
      drain();

      // random phases; a reset-free table stays full, so close points keep merging
      for (int phase = 0; phase < 6; phase++) begin
         case (phase % 3)
            0: write_reg(CSR_MERGE_FACTOR, 16'($urandom_range(0, 4095)));
            1: write_reg(CSR_MERGE_FACTOR, 16'($urandom_range(0, 64)));
            default: write_reg(CSR_MERGE_FACTOR, 16'h0FFF);
         endcase
         write_reg(CSR_MAX_DEPTH, (phase == 3) ? 16'd0 : 16'($urandom));
         for (int k = 0; k < 310; ) begin
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst && k < 310; b++, k++)
               send_impact(random_impact(($urandom_range(0, 1)) ? 64 : 4000,
                                         $urandom_range(0, 9) != 0));
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
            pause(gap);
         end
         drain();
      end

      drain();
      $display("covered %0d impacts: %0d merged, %0d filled, %0d dropped",
               impacts_sent, merges_seen, fills_seen, drops_seen);
      $display("register settings included zero and full-scale limits");
      if (error_count == 0 && board.pending.size() == 0)
         $display("proximity_merge_slot_table verification clean");
      else
         $display("proximity_merge_slot_table verification failed");
      $finish;
   end
endmodule
